// ===== rtl/core/grid_rectangle_first_fit_top_defines.svh =====
// assertion macros for the grid rectangle first-fit block
// used by grid_rectangle_first_fit_top
`ifndef GRID_RECTANGLE_FIRST_FIT_TOP_DEFINES_SVH
`define GRID_RECTANGLE_FIRST_FIT_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define GRFF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication outside reset
`define GRFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/grff_pkg.sv =====
// shared types and constants for the grid rectangle first-fit block
// no dependencies
`default_nettype none

package grff_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    localparam int IDX_W = 13;
    localparam int DIM_W = 7;

    localparam logic [IDX_W-1:0] IDX_NONE = {IDX_W{1'b1}};

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/grid_rectangle_first_fit_top.sv =====
// grid rectangle first-fit allocator: occupancy memory, sequencer, shared row unit
// depends on grff_pkg and grid_rectangle_first_fit_top_defines.svh
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// command   | start / busy         | operation, top_left, item_width, item_height
// result    | done (one cycle)     | fits, found_index
// config    | cfg_we               | cfg_index, cfg_data
//
// rows of the grid are read or written one at a time through the shared row unit;
// the corner index is split into column and row by repeated subtraction of the width.
// clear: goes from acceptance straight to the end state, which raises the strobe.
// mark and check: division steps, one bounds check, per item row a read, then a
// write or test, then the end state; search: per candidate one bounds check plus a
// read and a test per row tested (only a test when out of bounds), up to cols*rows
// candidates, then the end state.
// busy also covers the strobe cycle: a new item is accepted after it, not with it.
// reset empties the grid through valid bits per row, no clearing pass.
// the receiver cannot stall: done lasts exactly one cycle.

`include "grid_rectangle_first_fit_top_defines.svh"

module grid_rectangle_first_fit_top #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   operation,
    input  wire logic signed [grff_pkg::IDX_W-1:0] top_left,
    input  wire logic [grff_pkg::DIM_W-1:0]   item_width,
    input  wire logic [grff_pkg::DIM_W-1:0]   item_height,
    output logic                              done,
    output logic                              fits,
    output logic signed [grff_pkg::IDX_W-1:0] found_index,
    input  wire logic                         cfg_we,
    input  wire logic [0:0]                   cfg_index,
    input  wire logic [grff_pkg::DIM_W-1:0]   cfg_data
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int IW    = grff_pkg::IDX_W;
    localparam int DW    = grff_pkg::DIM_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;  // split corner into column and row
    localparam logic [2:0] S_BOUND = 3'd2;  // bounds check, build mask
    localparam logic [2:0] S_READ  = 3'd3;  // issue row read
    localparam logic [2:0] S_TEST  = 3'd4;  // test registered row data
    localparam logic [2:0] S_WRITE = 3'd5;  // mark row write
    localparam logic [2:0] S_DONE  = 3'd6;

    // occupancy memory with a valid bit per row
    logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0]    row_valid_reg;
    logic [MAX_COLUMNS-1:0] rd_data_reg;
    logic                   rd_valid_reg;

    logic [DW-1:0] gw_reg, gh_reg;
    logic [2:0]    state_reg, state_next;
    logic [1:0]    op_reg;
    logic [IW-1:0] idx_reg, idx_next;     // search candidate linear index
    logic [IW-1:0] rem_reg, rem_next;     // remainder during division
    logic [DW-1:0] sx_reg, sx_next;
    logic [IW-1:0] sy_reg, sy_next;
    logic [IW-1:0] y_reg, y_next;         // row being read or written
    logic [IW-1:0] ey_reg, ey_next;
    logic [MAX_COLUMNS-1:0] mask_reg, mask_next;
    logic [DW-1:0] iw_reg, ih_reg;
    logic          neg_reg;
    logic          fits_reg, fits_next;
    logic [IW-1:0] found_reg, found_next;
    logic          done_reg, done_next;

    // effective dimensions, clamped
    logic [DW-1:0] w_eff, h_eff;
    always_comb
    begin
        w_eff = (gw_reg == '0) ? DW'(1) : gw_reg;
        if (32'(w_eff) > MAX_COLUMNS)
            w_eff = DW'(MAX_COLUMNS);
        h_eff = (gh_reg == '0) ? DW'(1) : gh_reg;
        if (32'(h_eff) > MAX_ROWS)
            h_eff = DW'(MAX_ROWS);
    end

    logic [IW-1:0] n_cells;
    assign n_cells = IW'(14'(w_eff) * 14'(h_eff));

    // memory control from the sequencer
    logic                   mem_we, mem_re, clr_all;
    logic [ROW_W-1:0]       mem_addr;
    logic [MAX_COLUMNS-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_all)
                row_valid_reg <= '0;
            else if (mem_we)
                row_valid_reg[mem_addr] <= 1'b1;
            if (mem_re)
                rd_valid_reg <= row_valid_reg[mem_addr];
        end
    end

    logic [MAX_COLUMNS-1:0] row_now;
    assign row_now = rd_valid_reg ? rd_data_reg : '0;

    // span mask of cnt bits from sx
    function automatic logic [MAX_COLUMNS-1:0] span(input logic [DW-1:0] s,
                                                    input logic [DW:0] cnt);
        logic [MAX_COLUMNS-1:0] m;
        begin
            m = '0;
            for (int i = 0; i < MAX_COLUMNS; i++)
                if (32'(i) >= 32'(s) && 32'(i) < 32'(s) + 32'(cnt))
                    m[i] = 1'b1;
            return m;
        end
    endfunction

    logic [DW:0] ex_w;
    logic        empty_rect;
    assign empty_rect = (iw_reg == '0) || (ih_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        y_next     = y_reg;
        ey_next    = ey_reg;
        mask_next  = mask_reg;
        fits_next  = fits_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = y_reg[ROW_W-1:0];
        mem_wdata  = row_now | mask_reg;
        ex_w       = '0;
        case (state_reg)
            S_IDLE:
            begin
            end
            S_DIV:
            begin
                // one subtraction of the width per cycle
                if (rem_reg >= IW'(w_eff))
                begin
                    rem_next = rem_reg - IW'(w_eff);
                    sy_next  = sy_reg + IW'(1);
                end
                else
                begin
                    sx_next    = rem_reg[DW-1:0];
                    state_next = S_BOUND;
                end
            end
            S_BOUND:
            begin
                y_next = sy_reg;
                if (op_reg == grff_pkg::OP_MARK)
                begin
                    ex_w = ((DW+1)'(sx_reg) + (DW+1)'(iw_reg) > (DW+1)'(w_eff))
                           ? (DW+1)'(w_eff) - (DW+1)'(sx_reg) : (DW+1)'(iw_reg);
                    mask_next = span(sx_reg, ex_w);
                    ey_next = (sy_reg + IW'(ih_reg) > IW'(h_eff))
                              ? IW'(h_eff) : sy_reg + IW'(ih_reg);
                    if (empty_rect || neg_reg || sy_reg >= IW'(h_eff))
                        state_next = S_DONE;
                    else
                        state_next = S_READ;
                end
                else
                begin
                    mask_next = span(sx_reg, (DW+1)'(iw_reg));
                    ey_next   = sy_reg + IW'(ih_reg);
                    if (empty_rect)
                    begin
                        // an empty rectangle fits anywhere, search stops at the first cell
                        fits_next  = 1'b1;
                        if (op_reg == grff_pkg::OP_SEARCH)
                            found_next = idx_reg;
                        state_next = S_DONE;
                    end
                    else if (neg_reg
                             || (DW+1)'(sx_reg) + (DW+1)'(iw_reg) > (DW+1)'(w_eff)
                             || sy_reg >= IW'(h_eff)
                             || IW'(ih_reg) > IW'(h_eff) - sy_reg)
                        state_next = (op_reg == grff_pkg::OP_SEARCH) ? S_TEST : S_DONE;
                    else
                        state_next = S_READ;
                end
                if (op_reg == grff_pkg::OP_SEARCH && state_next == S_TEST)
                    fits_next = 1'b0;
                else if (op_reg == grff_pkg::OP_SEARCH && state_next == S_READ)
                    fits_next = 1'b1;
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = (op_reg == grff_pkg::OP_MARK) ? S_WRITE : S_TEST;
                if (op_reg != grff_pkg::OP_MARK)
                    fits_next = 1'b1;
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                y_next = y_reg + IW'(1);
                state_next = (y_reg + IW'(1) >= ey_reg) ? S_DONE : S_READ;
            end
            S_TEST:
            begin
                if (fits_reg && (row_now & mask_reg) == '0 && y_reg + IW'(1) < ey_reg)
                begin
                    y_next     = y_reg + IW'(1);
                    state_next = S_READ;
                end
                else
                begin
                    if (fits_reg && (row_now & mask_reg) != '0)
                        fits_next = 1'b0;
                    if (op_reg == grff_pkg::OP_SEARCH)
                    begin
                        if (fits_next)
                        begin
                            found_next = idx_reg;
                            state_next = S_DONE;
                        end
                        else if (idx_reg + IW'(1) >= n_cells)
                            state_next = S_DONE;
                        else
                        begin
                            // next candidate: advance column and row incrementally
                            idx_next = idx_reg + IW'(1);
                            if (sx_reg + DW'(1) >= w_eff)
                            begin
                                sx_next = '0;
                                sy_next = sy_reg + IW'(1);
                            end
                            else
                                sx_next = sx_reg + DW'(1);
                            state_next = S_BOUND;
                        end
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    logic accept;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gw_reg    <= DW'(8);
            gh_reg    <= DW'(8);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (cfg_we)
            begin
                if (cfg_index == grff_pkg::CFG_WIDTH)
                    gw_reg <= cfg_data;
                else
                    gh_reg <= cfg_data;
            end
            if (accept)
            begin
                case (operation)
                    grff_pkg::OP_CLEAR:  state_reg <= S_DONE;
                    grff_pkg::OP_SEARCH: state_reg <= S_BOUND;
                    default:             state_reg <= S_DIV;
                endcase
            end
            else
                state_reg <= state_next;
        end
    end

    // clear drops every row valid bit at acceptance
    assign clr_all = accept && (operation == grff_pkg::OP_CLEAR);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            iw_reg    <= item_width;
            ih_reg    <= item_height;
            // search ignores the corner
            neg_reg   <= top_left[IW-1] && (operation != grff_pkg::OP_SEARCH);
            rem_reg   <= top_left[IW-1] ? '0 : top_left;
            idx_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            y_reg     <= '0;
            ey_reg    <= '0;
            mask_reg  <= '0;
            fits_reg  <= 1'b0;
            found_reg <= grff_pkg::IDX_NONE;
        end
        else
        begin
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            y_reg     <= y_next;
            ey_reg    <= ey_next;
            mask_reg  <= mask_next;
            fits_reg  <= fits_next;
            found_reg <= found_next;
        end
    end

    assign busy        = (state_reg != S_IDLE) || done_reg;
    assign done        = done_reg;
    assign fits        = done_reg && (op_reg == grff_pkg::OP_CHECK
                                      || op_reg == grff_pkg::OP_SEARCH) && fits_reg;
    assign found_index = (done_reg && op_reg == grff_pkg::OP_SEARCH) ? found_reg
                                                                      : grff_pkg::IDX_NONE;

    // checks
    `GRFF_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done longer than one cycle")
    `GRFF_ASSERT_IMPL(a_busy_done, clk, rst_n, done, busy, "result while not busy")
    `GRFF_ASSERT_IMPL(a_found_fits, clk, rst_n, done && found_index != grff_pkg::IDX_NONE,
                      fits, "index found without fit")
    `GRFF_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "item taken, not busy")

endmodule

`default_nettype wire
